// ----- rtl/hbwd_pkg.sv -----
// Shared constants for the heartbeat watchdog table.
`default_nettype none
package hbwd_pkg;
    localparam int NUM_DEVICES_DEF = 16;
    localparam int TIME_BITS_DEF   = 32;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUTS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LATENCY  = 4'd1;

    localparam logic [7:0]  TIMEOUTS_RST = 8'd3;
    localparam logic [15:0] LATENCY_RST  = 16'd0;

    localparam logic FUNC_HEARTBEAT = 1'b0;
    localparam logic FUNC_TICK      = 1'b1;
endpackage
`default_nettype wire

// ----- rtl/multi_device_heartbeat_watchdog_top.sv -----
// Heartbeat watchdog over a table of device slots.
//
// Input channel (in_valid/in_ready) takes one item at a time: func selects a
// heartbeat (store stamp and interval for device_id, mark it alive) or a tick
// (time_ms is the current time; walk the live slots in ascending order).
// Output channel (out_valid/out_ready) returns one result per item.
// Stamps and intervals sit in one synchronous memory; a tick reads one slot
// per cycle through a three-stage read/compute/check pipeline, and the walk
// stops early when a slot fails. A heartbeat, or a tick before any heartbeat,
// skips the walk and goes straight to the result.
// The next item is taken once the result is loaded into the output register,
// so a result may wait there while the following item is already at work.
// When the receiver stalls, a finished result holds in its own stage until
// the output register frees, and no new item is taken meanwhile.
// Reset clears all alive and warning flags and the seen-any flag and loads
// the register defaults (timeouts 3, tolerance 0); the memory is not cleared,
// a slot's contents count only once a heartbeat has written it.
// Configuration writes through cfg_we/cfg_index/cfg_data, one per cycle.
`default_nettype none
module multi_device_heartbeat_watchdog_top #(
    parameter int NUM_DEVICES = hbwd_pkg::NUM_DEVICES_DEF,
    parameter int TIME_BITS   = hbwd_pkg::TIME_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [hbwd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [hbwd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           func,
    input  wire logic [3:0]                     device_id,
    input  wire logic [31:0]                    time_ms,
    input  wire logic [15:0]                    interval_ms,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                status,
    output logic [3:0]                          failed_id,
    output logic [15:0]                         warn_mask,
    output logic [15:0]                         living_mask,
    output logic                                living_changed
);
    localparam int IDX_W = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
    localparam int CNT_W = IDX_W + 1;
    localparam int MEM_W = TIME_BITS + 16;
    localparam int LIM_W = 24;
    localparam int CMP_W = (TIME_BITS > LIM_W) ? TIME_BITS : LIM_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_DEVICES - 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(NUM_DEVICES);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [7:0]             timeouts_reg;
    logic [15:0]            latency_reg;
    logic [NUM_DEVICES-1:0] valid_reg, valid_next;
    logic [NUM_DEVICES-1:0] warned_reg, warned_next;
    logic                   any_seen_reg, any_seen_next;

    logic [CNT_W-1:0]       iss_cnt_reg, iss_cnt_next;
    logic                   p1_vld_reg, p1_vld_next;
    logic                   p2_vld_reg, p2_vld_next;
    logic [IDX_W-1:0]       p1_idx_reg, p2_idx_reg;
    logic [MEM_W-1:0]       rd_data_reg;
    logic [TIME_BITS-1:0]   diff_reg;
    logic [LIM_W-1:0]       fail_lim_reg;
    logic [16:0]            warn_lim_reg;
    logic [TIME_BITS-1:0]   now_reg;

    logic                   res_status_reg, res_status_next;
    logic [3:0]             res_failed_reg, res_failed_next;
    logic [15:0]            res_warn_reg, res_warn_next;
    logic                   res_changed_reg, res_changed_next;
    logic                   out_valid_reg, out_valid_next;

    logic [MEM_W-1:0]       mem [NUM_DEVICES];

    logic                   in_xfer;
    logic                   hb_hit;
    logic [IDX_W-1:0]       hb_idx;
    logic [IDX_W-1:0]       iss_addr;
    logic                   issuing;
    logic                   d_pos;
    logic                   fail_hit;
    logic                   warn_hit;
    logic                   walk_done;
    logic                   out_load;
    logic [15:0]            warn_hot;
    logic [15:0]            live16;
    logic [TIME_BITS-1:0]   rd_stamp;
    logic [15:0]            rd_ivl;

    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign hb_hit   = (func == hbwd_pkg::FUNC_HEARTBEAT) && (32'(device_id) < NUM_DEVICES);
    assign hb_idx   = IDX_W'(device_id);
    assign iss_addr = iss_cnt_reg[IDX_W-1:0];
    assign issuing  = (state_reg == S_WALK) && (iss_cnt_reg < CNT_END);
    assign rd_stamp = rd_data_reg[MEM_W-1:16];
    assign rd_ivl   = rd_data_reg[15:0];

    // Negative elapsed time never exceeds a threshold.
    assign d_pos    = !diff_reg[TIME_BITS-1];
    assign fail_hit = p2_vld_reg && valid_reg[p2_idx_reg] && d_pos
                      && (CMP_W'(diff_reg) > CMP_W'(fail_lim_reg));
    assign warn_hit = p2_vld_reg && valid_reg[p2_idx_reg] && !fail_hit
                      && !warned_reg[p2_idx_reg] && d_pos
                      && (CMP_W'(diff_reg) > CMP_W'(warn_lim_reg));
    assign walk_done = fail_hit || (p2_vld_reg && (p2_idx_reg == LAST_IDX));
    assign out_load  = (state_reg == S_FIN) && (!out_valid_reg || out_ready);

    always_comb
    begin
        for (int j = 0; j < 16; j++)
        begin
            warn_hot[j] = (32'(p2_idx_reg) == j);
            live16[j]   = (j < NUM_DEVICES) ? valid_reg[j % NUM_DEVICES] : 1'b0;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        valid_next       = valid_reg;
        warned_next      = warned_reg;
        any_seen_next    = any_seen_reg;
        iss_cnt_next     = iss_cnt_reg;
        p1_vld_next      = 1'b0;
        p2_vld_next      = 1'b0;
        res_status_next  = res_status_reg;
        res_failed_next  = res_failed_reg;
        res_warn_next    = res_warn_reg;
        res_changed_next = res_changed_reg;
        out_valid_next   = out_valid_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    res_status_next  = 1'b0;
                    res_failed_next  = 4'd0;
                    res_warn_next    = 16'd0;
                    res_changed_next = 1'b0;
                    iss_cnt_next     = '0;
                    if (func == hbwd_pkg::FUNC_HEARTBEAT)
                    begin
                        if (hb_hit)
                        begin
                            res_changed_next    = !valid_reg[hb_idx];
                            valid_next[hb_idx]  = 1'b1;
                            warned_next[hb_idx] = 1'b0;
                            any_seen_next       = 1'b1;
                        end
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = any_seen_reg ? S_WALK : S_FIN;
                    end
                end
            end
            S_WALK:
            begin
                if (issuing)
                begin
                    iss_cnt_next = iss_cnt_reg + 1'b1;
                end
                // Drop the slots still in flight once the walk stops.
                p1_vld_next = issuing && !walk_done;
                p2_vld_next = p1_vld_reg && !walk_done;
                if (fail_hit)
                begin
                    valid_next[p2_idx_reg] = 1'b0;
                    res_status_next        = 1'b1;
                    res_failed_next        = 4'(p2_idx_reg);
                    res_changed_next       = 1'b1;
                end
                if (warn_hit)
                begin
                    warned_next[p2_idx_reg] = 1'b1;
                    res_warn_next           = res_warn_reg | warn_hot;
                end
                if (walk_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            timeouts_reg    <= hbwd_pkg::TIMEOUTS_RST;
            latency_reg     <= hbwd_pkg::LATENCY_RST;
            valid_reg       <= '0;
            warned_reg      <= '0;
            any_seen_reg    <= 1'b0;
            iss_cnt_reg     <= '0;
            p1_vld_reg      <= 1'b0;
            p2_vld_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
            res_status_reg  <= 1'b0;
            res_failed_reg  <= 4'd0;
            res_warn_reg    <= 16'd0;
            res_changed_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            valid_reg       <= valid_next;
            warned_reg      <= warned_next;
            any_seen_reg    <= any_seen_next;
            iss_cnt_reg     <= iss_cnt_next;
            p1_vld_reg      <= p1_vld_next;
            p2_vld_reg      <= p2_vld_next;
            out_valid_reg   <= out_valid_next;
            res_status_reg  <= res_status_next;
            res_failed_reg  <= res_failed_next;
            res_warn_reg    <= res_warn_next;
            res_changed_reg <= res_changed_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    hbwd_pkg::REG_TIMEOUTS: timeouts_reg <= cfg_data[7:0];
                    hbwd_pkg::REG_LATENCY:  latency_reg  <= cfg_data;
                    default:                ;
                endcase
            end
        end
    end

    // Writes happen only at a heartbeat transfer in idle, and read data is used
    // only during a walk, so a write never changes a slot whose read is in use.
    always_ff @(posedge clk)
    begin
        if (in_xfer && hb_hit)
        begin
            mem[hb_idx] <= {TIME_BITS'(time_ms), interval_ms};
        end
        rd_data_reg <= mem[iss_addr];
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            now_reg <= TIME_BITS'(time_ms);
        end
        p1_idx_reg   <= iss_addr;
        p2_idx_reg   <= p1_idx_reg;
        diff_reg     <= now_reg - rd_stamp;
        fail_lim_reg <= LIM_W'(rd_ivl) * LIM_W'(timeouts_reg);
        warn_lim_reg <= 17'(rd_ivl) + 17'(latency_reg);
        if (out_load)
        begin
            status         <= res_status_reg;
            failed_id      <= res_failed_reg;
            warn_mask      <= res_warn_reg;
            living_mask    <= live16;
            living_changed <= res_changed_reg;
        end
    end

    assign out_valid = out_valid_reg;
endmodule
`default_nettype wire

// ----- rtl/hbwd_checker.sv -----
// Port-level checks for the heartbeat watchdog, bound to the top level.
`default_nettype none
module hbwd_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           in_valid,
    input wire logic                           in_ready,
    input wire logic                           out_valid,
    input wire logic                           out_ready,
    input wire logic                           status,
    input wire logic [3:0]                     failed_id,
    input wire logic [15:0]                    warn_mask,
    input wire logic [15:0]                    living_mask,
    input wire logic                           living_changed
);
    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(failed_id)
            && $stable(warn_mask) && $stable(living_mask) && $stable(living_changed))
        else $error("stalled result changed");

    // One item at a time: no transfer right after a transfer.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is at work");

    a_run_id: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !status |-> failed_id == 4'd0)
        else $error("failed_id set without failure");

    // A failed device is removed and raises no warning on that tick.
    a_fail_removed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> living_changed && !living_mask[failed_id]
            && !warn_mask[failed_id])
        else $error("failed device still alive or warned");
endmodule

bind multi_device_heartbeat_watchdog_top hbwd_checker u_hbwd_checker (.*);
`default_nettype wire
